@@ hw/rtl/grid_mesh_index_sequencer_assert.svh @@
// Assertion macros for the grid mesh index sequencer checkers.
// Used by gmis_checker; no other dependencies.
`ifndef GRID_MESH_INDEX_SEQUENCER_ASSERT_SVH
`define GRID_MESH_INDEX_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define GMIS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gmis check failed");

// next-cycle implication
`define GMIS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gmis check failed");

`endif

@@ hw/rtl/gmis_pkg.sv @@
// Shared widths, codes and types of the grid mesh index sequencer.
// No dependencies.
package gmis_pkg;

	localparam int SEG_W     = 11;
	localparam int TOPO_W    = 2;
	localparam int IDX_W     = 21;
	localparam int LEN_W     = 23;
	localparam int PHASE_W   = 3;
	localparam int SECT_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_SEGMENTS = 1024;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HSEG = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VSEG = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TOPO = CFG_IDX_W'(2);

	localparam logic [TOPO_W-1:0] TOPO_POINTS = TOPO_W'(0);
	localparam logic [TOPO_W-1:0] TOPO_LINES  = TOPO_W'(1);
	localparam logic [TOPO_W-1:0] TOPO_TRIS   = TOPO_W'(2);
	localparam logic [TOPO_W-1:0] TOPO_STRIP  = TOPO_W'(3);

	localparam logic [SECT_W-1:0] SECT_HEAD = SECT_W'(0);
	localparam logic [SECT_W-1:0] SECT_BODY = SECT_W'(1);
	localparam logic [SECT_W-1:0] SECT_JOIN = SECT_W'(2);

	localparam logic [SEG_W-1:0]  HSEG_RST = SEG_W'(1);
	localparam logic [SEG_W-1:0]  VSEG_RST = SEG_W'(1);
	localparam logic [TOPO_W-1:0] TOPO_RST = TOPO_TRIS;

	typedef struct packed {
		logic restart;
	} req_item_t;

	typedef struct packed {
		logic              clr;
		logic              err;
		logic [TOPO_W-1:0] topo;
		logic [SEG_W-1:0]  h;
		logic [SEG_W-1:0]  w;
		logic [IDX_W-1:0]  vw;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  len_m1;
	} geom_t;

endpackage

@@ hw/rtl/gmis_req_if.sv @@
// Request channel of the grid mesh index sequencer.
// Depends on gmis_pkg.
interface gmis_req_if import gmis_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

@@ hw/rtl/gmis_rsp_if.sv @@
// Result channel of the grid mesh index sequencer.
// Depends on gmis_pkg for field widths.
interface gmis_rsp_if import gmis_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] vtx_idx;
	logic             last_in_sequence;
	logic [LEN_W-1:0] sequence_length;
	logic             status;

	modport source (output valid, output vtx_idx, output last_in_sequence,
		output sequence_length, output status, input ready);
	modport sink (input valid, input vtx_idx, input last_in_sequence,
		input sequence_length, input status, output ready);
endinterface

@@ hw/rtl/gmis_queue.sv @@
// Short request queue between front and back.
// Depends on gmis_pkg.
module gmis_queue import gmis_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  req_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output req_item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	req_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/gmis_front.sv @@
// Front end: configuration registers, grid geometry and sequence length,
// request acceptance into the queue. Depends on gmis_pkg, gmis_req_if.
module gmis_front import gmis_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SEG_W-1:0]     cfg_wdata,
	gmis_req_if.sink             req,
	output logic                 q_push,
	output req_item_t            q_item,
	input  logic                 q_full,
	output geom_t                geom
);

	logic [SEG_W-1:0]   hseg_q;
	logic [SEG_W-1:0]   vseg_q;
	logic [TOPO_W-1:0]  topo_q;
	geom_t              geom_q;

	logic               cfg_clr;
	logic [SEG_W-1:0]   hc;
	logic [SEG_W-1:0]   vc;
	logic [2*SEG_W-1:0] hv;
	logic [LEN_W-1:0]   len_pts;
	logic [LEN_W-1:0]   len_lin;
	logic [LEN_W-1:0]   len_tri;
	logic [LEN_W-1:0]   len_stp;
	logic [LEN_W-1:0]   len_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hseg_q <= HSEG_RST;
			vseg_q <= VSEG_RST;
			topo_q <= TOPO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HSEG: hseg_q <= cfg_wdata;
				REG_VSEG: vseg_q <= cfg_wdata;
				REG_TOPO: topo_q <= cfg_wdata[TOPO_W-1:0];
				default:  ;
			endcase
		end
	end

	assign cfg_clr = cfg_we && (cfg_idx == REG_HSEG || cfg_idx == REG_VSEG
		|| cfg_idx == REG_TOPO);

	assign hc = (hseg_q > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : hseg_q;
	assign vc = (vseg_q > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : vseg_q;
	assign hv = hc * vc;

	assign len_pts = LEN_W'(hv) + LEN_W'(hc) + LEN_W'(vc) + LEN_W'(1);
	assign len_lin = (LEN_W'(hc) << 1) + (LEN_W'(vc) << 1) + LEN_W'(4);
	assign len_tri = (LEN_W'(hv) << 2) + (LEN_W'(hv) << 1);
	assign len_stp = (LEN_W'(hv) << 1) + (LEN_W'(vc) << 2) - LEN_W'(2);

	always_comb begin
		unique case (topo_q)
			TOPO_POINTS: len_sel = len_pts;
			TOPO_LINES:  len_sel = len_lin;
			TOPO_TRIS:   len_sel = len_tri;
			default:     len_sel = len_stp;
		endcase
	end

	// geometry is registered from the config registers, in the cycle after they change
	always_ff @(posedge clk) begin
		geom_q.clr    <= 1'b0;
		geom_q.err    <= (hc == '0) || (vc == '0);
		geom_q.topo   <= topo_q;
		geom_q.h      <= hc;
		geom_q.w      <= hc + 1'b1;
		geom_q.vw     <= IDX_W'(hv) + IDX_W'(vc);
		geom_q.len    <= len_sel;
		geom_q.len_m1 <= len_sel - 1'b1;
	end

	always_comb begin
		geom     = geom_q;
		geom.clr = cfg_clr;
	end

	assign req.ready      = !q_full;
	assign q_push         = req.valid && !q_full;
	assign q_item.restart = req.restart;

endmodule

@@ hw/rtl/gmis_back.sv @@
// Back end: walk counters, index forming and the result register.
// Depends on gmis_pkg, gmis_rsp_if.
module gmis_back import gmis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  geom_t     geom,
	input  logic      head_valid,
	input  req_item_t head_item,
	output logic      pop,
	gmis_rsp_if.source rsp
);

	logic [LEN_W-1:0]   pos_q;
	logic [IDX_W-1:0]   base_q;
	logic [SEG_W-1:0]   col_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SECT_W-1:0]  sect_q;

	logic               rsp_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               last_q;
	logic [LEN_W-1:0]   len_q;
	logic               stat_q;

	logic [LEN_W-1:0]   pos_nx;
	logic [IDX_W-1:0]   base_nx;
	logic [SEG_W-1:0]   col_nx;
	logic [PHASE_W-1:0] phase_nx;
	logic [SECT_W-1:0]  sect_nx;
	logic [IDX_W-1:0]   idx;
	logic               last;

	assign pop = head_valid && (!rsp_valid_q || rsp.ready);

	always_comb begin
		logic [LEN_W-1:0]   c_pos;
		logic [IDX_W-1:0]   c_base;
		logic [SEG_W-1:0]   c_col;
		logic [PHASE_W-1:0] c_phase;
		logic [SECT_W-1:0]  c_sect;
		logic               use_c;
		logic [IDX_W-1:0]   off;
		logic               col_end;
		logic [IDX_W-1:0]   w_x;
		logic [IDX_W-1:0]   h_x;

		c_pos   = head_item.restart ? '0 : pos_q;
		c_base  = head_item.restart ? '0 : base_q;
		c_col   = head_item.restart ? '0 : col_q;
		c_phase = head_item.restart ? '0 : phase_q;
		c_sect  = head_item.restart ? '0 : sect_q;
		w_x     = IDX_W'(geom.w);
		h_x     = IDX_W'(geom.h);
		col_end = (c_col >= geom.h);

		use_c    = 1'b1;
		off      = '0;
		pos_nx   = c_pos + 1'b1;
		base_nx  = c_base;
		col_nx   = c_col;
		phase_nx = c_phase;
		sect_nx  = c_sect;

		unique case (geom.topo)
			TOPO_POINTS: begin
				if (col_end) begin
					col_nx  = '0;
					base_nx = c_base + w_x;
				end else begin
					col_nx = c_col + 1'b1;
				end
			end
			TOPO_LINES: begin
				if (c_sect == SECT_HEAD) begin
					off = (c_phase != '0) ? geom.vw : '0;
				end else begin
					use_c = 1'b0;
					off   = (c_phase != '0) ? h_x : '0;
				end
				if (c_phase == '0) begin
					phase_nx = PHASE_W'(1);
				end else begin
					phase_nx = '0;
					if (c_sect == SECT_HEAD) begin
						if (col_end) begin
							sect_nx = SECT_BODY;
							base_nx = '0;
							col_nx  = '0;
						end else begin
							col_nx = c_col + 1'b1;
						end
					end else begin
						base_nx = c_base + w_x;
					end
				end
			end
			TOPO_TRIS: begin
				case (c_phase) inside
					PHASE_W'(1), PHASE_W'(4): off = w_x;
					PHASE_W'(2), PHASE_W'(3): off = IDX_W'(1);
					PHASE_W'(5):              off = w_x + 1'b1;
					default:                  off = '0;
				endcase
				if (c_phase < PHASE_W'(5)) begin
					phase_nx = c_phase + 1'b1;
				end else begin
					phase_nx = '0;
					if ({1'b0, c_col} + 1'b1 >= {1'b0, geom.h}) begin
						col_nx  = '0;
						base_nx = c_base + w_x;
					end else begin
						col_nx = c_col + 1'b1;
					end
				end
			end
			default: begin
				if (c_sect == SECT_HEAD) begin
					use_c = 1'b0;
					off   = (c_phase != '0) ? w_x : '0;
				end else if (c_sect == SECT_BODY) begin
					off = (c_phase != '0) ? w_x : '0;
				end else begin
					use_c = 1'b0;
					off   = (c_phase != '0) ? w_x : w_x + h_x;
				end
				if (c_phase == '0) begin
					phase_nx = PHASE_W'(1);
				end else begin
					phase_nx = '0;
					if (c_sect == SECT_HEAD) begin
						sect_nx = SECT_BODY;
						col_nx  = SEG_W'(1);
					end else if (c_sect == SECT_BODY) begin
						if (col_end) begin
							sect_nx = SECT_JOIN;
						end else begin
							col_nx = c_col + 1'b1;
						end
					end else begin
						sect_nx = SECT_HEAD;
						col_nx  = '0;
						base_nx = c_base + w_x;
					end
				end
			end
		endcase

		idx  = c_base + (use_c ? IDX_W'(c_col) : '0) + off;
		last = (c_pos == geom.len_m1);

		if (geom.err || last) begin
			pos_nx   = '0;
			base_nx  = '0;
			col_nx   = '0;
			phase_nx = '0;
			sect_nx  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			base_q  <= '0;
			col_q   <= '0;
			phase_q <= '0;
			sect_q  <= '0;
		end else if (geom.clr) begin
			pos_q   <= '0;
			base_q  <= '0;
			col_q   <= '0;
			phase_q <= '0;
			sect_q  <= '0;
		end else if (pop) begin
			pos_q   <= pos_nx;
			base_q  <= base_nx;
			col_q   <= col_nx;
			phase_q <= phase_nx;
			sect_q  <= sect_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q  <= geom.err ? '0 : idx;
			last_q <= !geom.err && last;
			len_q  <= geom.err ? '0 : geom.len;
			stat_q <= geom.err;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.vtx_idx          = idx_q;
	assign rsp.last_in_sequence = last_q;
	assign rsp.sequence_length  = len_q;
	assign rsp.status           = stat_q;

endmodule

@@ hw/rtl/grid_mesh_index_sequencer.sv @@
// Grid mesh index sequencer top level: front, request queue, back.
// Depends on gmis_pkg, gmis_req_if, gmis_rsp_if, gmis_queue, gmis_front, gmis_back.
//
// channel  dir  fields
// req      in   restart
// rsp      out  vtx_idx, last_in_sequence, sequence_length, status
// cfg      in   cfg_we, cfg_idx, cfg_wdata (write only)
//
// One request per clock while the queue is not full. A taken request is written into the queue;
// its pop from the queue loads the result register, which drives rsp.
// The queue (QDEPTH entries) lets requests be taken while a result waits on rsp.
// Geometry and sequence length are registered from the config registers after a config write.
// Reset clears the walk counters and restores the register defaults; no sweep.
module grid_mesh_index_sequencer import gmis_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SEG_W-1:0]     cfg_wdata,
	gmis_req_if.sink             req,
	gmis_rsp_if.source           rsp
);

	logic      q_push;
	req_item_t q_item;
	logic      q_full;
	logic      q_pop;
	logic      q_head_valid;
	req_item_t q_head;
	geom_t     geom;

	gmis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_push    (q_push),
		.q_item    (q_item),
		.q_full    (q_full),
		.geom      (geom)
	);

	gmis_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head)
	);

	gmis_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.head_valid (q_head_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.rsp        (rsp)
	);

endmodule

@@ hw/rtl/gmis_checker.sv @@
// Port-level checks on the grid mesh index sequencer result channel.
// Depends on gmis_pkg and grid_mesh_index_sequencer_assert.svh; bound to the top.
`include "grid_mesh_index_sequencer_assert.svh"

module gmis_checker import gmis_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [IDX_W-1:0] vtx_idx,
	input logic             last_in_sequence,
	input logic [LEN_W-1:0] sequence_length,
	input logic             status
);

	logic [IDX_W+LEN_W+1:0] rsp_bits;
	logic                   err_shape;

	assign rsp_bits  = {vtx_idx, last_in_sequence, sequence_length, status};
	assign err_shape = (vtx_idx == '0) && !last_in_sequence && (sequence_length == '0);

	`GMIS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bits))

	`GMIS_ASSERT_NOW(a_err_result, clk, arst_n, rsp_valid && status, err_shape)

	`GMIS_ASSERT_NOW(a_ok_len, clk, arst_n, rsp_valid && !status, sequence_length != '0)

endmodule

bind grid_mesh_index_sequencer gmis_checker u_gmis_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.vtx_idx          (rsp.vtx_idx),
	.last_in_sequence (rsp.last_in_sequence),
	.sequence_length  (rsp.sequence_length),
	.status           (rsp.status)
);
